@@ hdl/u2l_pkg.sv @@
package u2l_pkg;

   // UTF-8 byte classes, tested with inside ranges
   localparam logic [7:0] ASCII_LO  = 8'h00;
   localparam logic [7:0] ASCII_HI  = 8'h7F;
   localparam logic [7:0] LEAD2_LO  = 8'hC0;
   localparam logic [7:0] LEAD2_HI  = 8'hDF;
   localparam logic [7:0] LEAD3_LO  = 8'hE0;
   localparam logic [7:0] LEAD3_HI  = 8'hEF;
   localparam logic [7:0] LEAD4_LO  = 8'hF0;
   localparam logic [7:0] LEAD4_HI  = 8'hF7;

   // sequence length codes (four bytes wraps to zero in two bits)
   localparam logic [1:0] SEQ_FOUR  = 2'd0;
   localparam logic [1:0] SEQ_TWO   = 2'd2;
   localparam logic [1:0] SEQ_THREE = 2'd3;

   localparam int unsigned CODE_W = 21;

   // the one code point above Latin-1 that has its own mapping
   localparam logic [CODE_W-1:0] TM_CODE_POINT = 21'd8482;
   localparam logic [7:0]        TM_CHAR       = 8'd153;
   localparam logic [CODE_W-1:0] LATIN1_MAX    = 21'd255;

   localparam logic [7:0] REPL_RESET = 8'd63;

   typedef struct packed {
      logic [1:0]        bytes_left;
      logic [1:0]        seq_length;
      logic [CODE_W-1:0] code_accum;
   } dec_state_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       bad_lead;
   } result_type;

endpackage

@@ hdl/u2l_if.sv @@
interface u2l_req_if;
   import u2l_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface u2l_rsp_if;
   import u2l_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       bad_lead;

   modport source (output valid, output out_char, output bad_lead, input ready);
   modport sink   (input valid, input out_char, input bad_lead, output ready);
endinterface

@@ hdl/u2l_decode.sv @@
module u2l_decode
   import u2l_pkg::*;
(
   input  dec_state_type state,
   input  logic [7:0]    in_byte,
   input  logic [7:0]    repl_char,
   output dec_state_type state_next,
   output logic          res_valid,
   output result_type    res
);

   logic [CODE_W-1:0] accum_shift;
   logic [1:0]        left_dec;

   assign accum_shift = {state.code_accum[CODE_W-7:0], in_byte[5:0]};
   assign left_dec    = state.bytes_left - 2'd1;

   // one decode step per request
   always_comb begin
      state_next   = state;
      res_valid    = 1'b0;
      res.out_char = 8'd0;
      res.bad_lead = 1'b0;

      if (state.bytes_left == 2'd0) begin
         // no sequence open: classify the byte
         if (in_byte inside {[ASCII_LO:ASCII_HI]}) begin
            res_valid    = 1'b1;
            res.out_char = in_byte;
         end else if (in_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
            state_next.seq_length = SEQ_TWO;
            state_next.bytes_left = 2'd1;
            state_next.code_accum = {{(CODE_W-5){1'b0}}, in_byte[4:0]};
         end else if (in_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
            state_next.seq_length = SEQ_THREE;
            state_next.bytes_left = 2'd2;
            state_next.code_accum = {{(CODE_W-4){1'b0}}, in_byte[3:0]};
         end else if (in_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
            state_next.seq_length = SEQ_FOUR;
            state_next.bytes_left = 2'd3;
            state_next.code_accum = {{(CODE_W-3){1'b0}}, in_byte[2:0]};
         end else begin
            res_valid    = 1'b1;
            res.bad_lead = 1'b1;
         end
      end else if (state.seq_length == SEQ_TWO) begin
         // two-byte sequence: lead bits 1:0 land on 7:6, bit 6 is or-ed
         res_valid             = 1'b1;
         res.out_char          = {state.code_accum[1],
                                  in_byte[6] | state.code_accum[0],
                                  in_byte[5:0]};
         state_next.bytes_left = left_dec;
         state_next.seq_length = 2'd0;
         state_next.code_accum = '0;
      end else begin
         // three or four bytes: gather six bits per continuation
         state_next.bytes_left = left_dec;
         state_next.code_accum = accum_shift;
         if (left_dec == 2'd0) begin
            res_valid             = 1'b1;
            state_next.seq_length = 2'd0;
            state_next.code_accum = '0;
            if (accum_shift > LATIN1_MAX) begin
               res.out_char = (accum_shift == TM_CODE_POINT) ? TM_CHAR : repl_char;
            end else begin
               res.out_char = accum_shift[7:0];
            end
         end
      end
   end

endmodule

@@ hdl/u2l_rsp_reg.sv @@
module u2l_rsp_reg
   import u2l_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type res,
   output logic       free,
   u2l_rsp_if.source  rsp_ch
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign free     = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   // result register: holds while the sink stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.out_char = res_ff.out_char;
   assign rsp_ch.bad_lead = res_ff.bad_lead;

endmodule

@@ hdl/utf8_to_latin1_decoder.sv @@
// A request that completes a character shows its result in the cycle after acceptance.
// Throughput: one byte per cycle unless the sink stalls; the single result register sets
// the pace and takes a new request in the cycle its current result is taken.
// Reset (synchronous, active high): no sequence open, result register empty,
// replacement character back to '?'.
module utf8_to_latin1_decoder
   import u2l_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   u2l_req_if.sink    req_ch,
   u2l_rsp_if.source  rsp_ch
);

   dec_state_type state_ff, state_in;
   logic [7:0]    repl_ff;
   logic          res_valid;
   result_type    res;
   logic          rsp_free;
   logic          req_accept;

   assign req_ch.ready = rsp_free;
   assign req_accept   = req_ch.valid && rsp_free;

   // replacement character register
   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPL_RESET;
      end else if (csr_wr_en) begin
         repl_ff <= csr_wr_data;
      end
   end

   // sequence state advances on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   u2l_decode u_decode (
      .state      (state_ff),
      .in_byte    (req_ch.in_byte),
      .repl_char  (repl_ff),
      .state_next (state_in),
      .res_valid  (res_valid),
      .res        (res)
   );

   u2l_rsp_reg u_rsp_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (req_accept && res_valid),
      .res    (res),
      .free   (rsp_free),
      .rsp_ch (rsp_ch)
   );

   // idle state carries no leftover accumulation
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_left == 2'd0 |-> state_ff.seq_length == 2'd0 && state_ff.code_accum == '0)
      else $error("idle decoder state not cleared");

   // an open two-byte sequence always waits for exactly one byte
   a_two_left: assert property (@(posedge clock) disable iff (reset)
      state_ff.seq_length == SEQ_TWO |-> state_ff.bytes_left == 2'd1)
      else $error("two-byte sequence with wrong count");

   // ASCII outside a sequence passes straight through
   a_ascii: assert property (@(posedge clock) disable iff (reset)
      req_accept && state_ff.bytes_left == 2'd0 && !req_ch.in_byte[7] |=>
         rsp_ch.valid && rsp_ch.out_char == $past(req_ch.in_byte) && !rsp_ch.bad_lead)
      else $error("ASCII byte not passed through");

endmodule
